// ===== rtl/fasc_pkg.sv =====
// Shared types, constants and the set membership function of the fuzzy controller.
package fasc_pkg;

  // Fuzzy sets NB..PB
  localparam int SETS    = 7;
  localparam int SET_NB  = 0;
  localparam int SET_PB  = SETS - 1;
  localparam int SLOPE   = 30;

  // Widths
  localparam int IN_W    = 8;               // angle / speed
  localparam int X_W     = 10;              // working width for membership math
  localparam int W_W     = 5;               // strength 0..30
  localparam int PT_W    = 10;              // point sum constants
  localparam int WD_W    = 3;               // set width constants
  localparam int NUM_W   = 18;              // signed numerator
  localparam int MAG_W   = NUM_W - 1;       // numerator magnitude
  localparam int FRAC_W  = 8;               // 1/256 output units
  localparam int ACC_W   = MAG_W + FRAC_W;  // dividend bits
  localparam int DEN_W   = 11;              // denominator
  localparam int REM_W   = DEN_W + 1;       // partial remainder
  localparam int OUT_W   = 16;

  // Divider organization: one quotient bit per step, several steps per stage
  localparam int DIV_STEPS  = 5;
  localparam int DIV_STAGES = ACC_W / DIV_STEPS;

  // Pipeline: fuzzify, accumulate, divider stages, output
  localparam int NSTG = DIV_STAGES + 3;

  typedef logic [W_W-1:0] str_t;
  typedef str_t str_arr_t [SETS];

  // Divider pipeline payload
  typedef struct packed {
    logic             neg;
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rem;
    logic [ACC_W-1:0] acc;
  } div_t;

  // Set centers, point sums and widths
  localparam logic signed [X_W-1:0] CENTER [SETS] = '{
    -10'sd90, -10'sd60, -10'sd30, 10'sd0, 10'sd30, 10'sd60, 10'sd90
  };
  localparam logic signed [PT_W-1:0] PSUM [SETS] = '{
    -10'sd300, -10'sd420, -10'sd210, 10'sd0, 10'sd210, 10'sd420, 10'sd300
  };
  localparam logic [WD_W-1:0] SWIDTH [SETS] = '{
    3'd3, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd3
  };

  // Membership of x in set k, scaled to 0..30
  function automatic str_t grade(input int k, input logic signed [IN_W-1:0] x);
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] lo;
    logic signed [X_W-1:0] hi;
    logic signed [X_W-1:0] v;
    xs = X_W'(x);
    lo = xs - (CENTER[k] - X_W'(SLOPE));
    hi = (CENTER[k] + X_W'(SLOPE)) - xs;
    if (k == SET_NB) begin
      v = hi;                       // left shoulder
    end else if (k == SET_PB) begin
      v = lo;                       // right shoulder
    end else begin
      v = (lo < hi) ? lo : hi;
    end
    if (v < 0) begin
      return '0;
    end else if (v > X_W'(SLOPE)) begin
      return W_W'(SLOPE);
    end else begin
      return v[W_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/fasc_fuzz.sv =====
// Stage 1: speed sign fix, fuzzification of both inputs and per-set rule strengths.
module fasc_fuzz (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [fasc_pkg::IN_W-1:0] angle_i,
  input  logic signed [fasc_pkg::IN_W-1:0] speed_i,
  output fasc_pkg::str_arr_t             str_o
);

  logic signed [fasc_pkg::IN_W-1:0] spd;
  fasc_pkg::str_arr_t               str_d, str_q;

  // Speed is mirrored when a negative angle meets a positive speed
  always_comb begin
    spd = speed_i;
    if (angle_i < 0 && speed_i > 0) begin
      spd = -speed_i;
    end
  end

  // Rule strength per set: the nonzero grade if one is zero, else the minimum
  always_comb begin
    for (int k = 0; k < fasc_pkg::SETS; k++) begin
      fasc_pkg::str_t ga;
      fasc_pkg::str_t gs;
      ga = fasc_pkg::grade(k, angle_i);
      gs = fasc_pkg::grade(k, spd);
      if (ga == '0 || gs == '0) begin
        str_d[k] = ga | gs;         // one side is zero, so this is the sum
      end else begin
        str_d[k] = (ga < gs) ? ga : gs;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      str_q <= str_d;
    end
  end

  assign str_o = str_q;

endmodule

// ===== rtl/fasc_accum.sv =====
// Stage 2: weighted sums for numerator and denominator, set up for division.
module fasc_accum (
  input  logic               clk_i,
  input  logic               en_i,
  input  fasc_pkg::str_arr_t str_i,
  output fasc_pkg::div_t     div_o
);

  logic signed [fasc_pkg::NUM_W-1:0] num;
  logic        [fasc_pkg::DEN_W-1:0] den;
  logic        [fasc_pkg::MAG_W-1:0] mag;
  fasc_pkg::div_t                    div_d, div_q;

  // Sum of strength times constants over the seven sets
  always_comb begin
    num = '0;
    den = '0;
    for (int k = 0; k < fasc_pkg::SETS; k++) begin
      num = num + fasc_pkg::NUM_W'($signed({1'b0, str_i[k]}))
                * fasc_pkg::NUM_W'(fasc_pkg::PSUM[k]);
      den = den + fasc_pkg::DEN_W'(str_i[k]) * fasc_pkg::DEN_W'(fasc_pkg::SWIDTH[k]);
    end
  end

  // Sign-magnitude split; dividend is |num| * 256
  always_comb begin
    mag        = num[fasc_pkg::NUM_W-1] ? fasc_pkg::MAG_W'(-num)
                                        : num[fasc_pkg::MAG_W-1:0];
    div_d.neg  = num[fasc_pkg::NUM_W-1];
    div_d.den  = den;
    div_d.rem  = '0;
    div_d.acc  = {mag, {fasc_pkg::FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

// ===== rtl/fasc_div_stage.sv =====
// One restoring divider stage: DIV_STEPS quotient bits per enabled clock, shifted into acc.
module fasc_div_stage (
  input  logic           clk_i,
  input  logic           en_i,
  input  fasc_pkg::div_t div_i,
  output fasc_pkg::div_t div_o
);

  fasc_pkg::div_t div_d, div_q;

  // Shift-subtract steps; the dividend leaves acc at the top, quotient enters below
  always_comb begin
    logic [fasc_pkg::REM_W-1:0] r;
    logic                       qb;
    div_d = div_i;
    for (int s = 0; s < fasc_pkg::DIV_STEPS; s++) begin
      r  = {div_d.rem[fasc_pkg::REM_W-2:0], div_d.acc[fasc_pkg::ACC_W-1]};
      qb = (r >= {1'b0, div_d.den});
      div_d.rem = qb ? (r - {1'b0, div_d.den}) : r;
      div_d.acc = {div_d.acc[fasc_pkg::ACC_W-2:0], qb};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

// ===== rtl/fuzzy_angle_speed_controller.sv =====
// Fuzzy angle/speed controller top level: pipeline control, divider chain, output stage.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries a signed 8-bit angle and a
//   signed 8-bit speed per request. Output channel (out_valid_o / out_ready_i)
//   returns one signed 16-bit drive value per request, in 1/256 units,
//   truncated toward zero, in request order.
//   Stages from input acceptance to output valid: fuzzify, accumulate, five
//   divider stages, output register.
//   Throughput: one request per cycle when the output is not stalled. The divider
//   resolves five quotient bits per stage, so the 25-bit quotient takes five stages.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles collapse. When the receiver holds out_ready_i low, results stay in
//   place; in_ready_o drops only once every stage holds a request.
//   Reset (rst_ni low, asynchronous) empties the pipeline; no request or
//   result is pending afterwards. There is no configuration.
module fuzzy_angle_speed_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [fasc_pkg::IN_W-1:0] angle_i,
  input  logic signed [fasc_pkg::IN_W-1:0] speed_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [fasc_pkg::OUT_W-1:0] drive_o
);

  localparam int NSTG  = fasc_pkg::NSTG;
  localparam int S_DIV = 2;              // first divider stage index
  localparam int S_OUT = NSTG - 1;

  logic [NSTG-1:0]    v_q, v_d, en;
  fasc_pkg::str_arr_t str;
  fasc_pkg::div_t     div [fasc_pkg::DIV_STAGES+1];
  logic signed [fasc_pkg::OUT_W-1:0] drive_d, drive_q;

  // Stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[S_OUT] = !v_q[S_OUT] || out_ready_i;
    for (int k = S_OUT - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Valid bits follow the data
  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[S_OUT];

  // Fuzzification and rule strengths
  fasc_fuzz u_fuzz (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .angle_i (angle_i),
    .speed_i (speed_i),
    .str_o   (str)
  );

  // Weighted sums
  fasc_accum u_accum (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .str_i (str),
    .div_o (div[0])
  );

  // Divider chain
  for (genvar j = 0; j < fasc_pkg::DIV_STAGES; j++) begin : g_div
    fasc_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (en[S_DIV+j]),
      .div_i (div[j]),
      .div_o (div[j+1])
    );
  end

  // Output stage: restore the sign of the quotient
  always_comb begin
    drive_d = div[fasc_pkg::DIV_STAGES].acc[fasc_pkg::OUT_W-1:0];
    if (div[fasc_pkg::DIV_STAGES].neg) begin
      drive_d = -div[fasc_pkg::DIV_STAGES].acc[fasc_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

  // Input backpressure only arises from a stalled, completely full pipeline
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q) && !out_ready_i)
    else $error("in_ready_o low while pipeline has room");

  // Result stays within the defined drive range
  a_drive_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_o <= 16'sd25600) && (drive_o >= -16'sd25600))
    else $error("drive out of range");

  // Final partial remainder is below the divisor
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S_OUT-1] |-> div[fasc_pkg::DIV_STAGES].rem < {1'b0, div[fasc_pkg::DIV_STAGES].den})
    else $error("divider remainder not reduced");

  // Denominator is never zero for a live request
  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> div[0].den != '0)
    else $error("zero denominator");

  // A result taken with nothing behind it leaves the output stage empty
  a_out_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !v_q[S_OUT-1] |=> !out_valid_o)
    else $error("output repeated");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the fuzzy angle/speed controller: directed and random requests.
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 20;     // margin after the last result
  localparam int NUM_RANDOM   = 630;
  localparam int DRAIN_EVERY  = 97;
  localparam int REPORT_MAX   = 10;
  localparam int HOLD_AT      = 300;    // results seen before the long receiver hold-off
  localparam int HOLD_LEN     = 80;

  // Receiver stall patterns
  localparam int RX_FREE      = 0;
  localparam int RX_COIN      = 1;
  localparam int RX_SPARSE    = 2;
  localparam int RX_MOSTLY    = 3;

  localparam int IN_W  = fasc_pkg::IN_W;
  localparam int OUT_W = fasc_pkg::OUT_W;

  typedef struct {
    logic signed [IN_W-1:0] angle;
    logic signed [IN_W-1:0] speed;
    bit                     drain_first;  // wait for all results before offering
  } ctrl_req_t;

  typedef struct {
    logic signed [IN_W-1:0]  angle;
    logic signed [IN_W-1:0]  speed;
    logic signed [OUT_W-1:0] drive;
  } drive_exp_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic signed [IN_W-1:0]  angle_i     = '0;
  logic signed [IN_W-1:0]  speed_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] drive_o;

  ctrl_req_t  pending_reqs[$];
  drive_exp_t drive_expected[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;

  fuzzy_angle_speed_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .angle_i     (angle_i),
    .speed_i     (speed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Membership of x in set idx, scaled to 0..30
  function automatic int member_grade(input int idx, input int x);
    int c;
    int v;
    c = 30 * idx - 90;
    if (idx == fasc_pkg::SET_NB) begin
      v = (c + 30) - x;
    end else if (idx == fasc_pkg::SET_PB) begin
      v = x - (c - 30);
    end else begin
      v = 30 - ((x > c) ? x - c : c - x);
    end
    if (v < 0) begin
      v = 0;
    end else if (v > 30) begin
      v = 30;
    end
    return v;
  endfunction

  function automatic int set_point_sum(input int idx);
    case (idx)
      0:       return -300;
      1:       return -420;
      2:       return -210;
      3:       return 0;
      4:       return 210;
      5:       return 420;
      default: return 300;
    endcase
  endfunction

  // Weighted centroid of the seven rule strengths, in 1/256 units
  function automatic logic signed [OUT_W-1:0] predict_drive(input logic signed [IN_W-1:0] ang,
                                                            input logic signed [IN_W-1:0] spd);
    int a;
    int s;
    int ga;
    int gs;
    int w;
    int num;
    int den;
    int q;
    a = int'(ang);
    s = int'(spd);
    num = 0;
    den = 0;
    q = 0;
    // speed is mirrored for a negative angle with positive speed
    if (a < 0 && s > 0) begin
      s = -s;
    end
    for (int idx = 0; idx < 7; idx++) begin
      ga = member_grade(idx, a);
      gs = member_grade(idx, s);
      if (ga == 0 || gs == 0) begin
        w = ga + gs;
      end else begin
        w = (ga < gs) ? ga : gs;
      end
      num += w * set_point_sum(idx);
      den += w * ((idx == fasc_pkg::SET_NB || idx == fasc_pkg::SET_PB) ? 3 : 6);
    end
    if (den > 0) begin
      q = (num * 256) / den;  // int division truncates toward zero
    end
    return q[OUT_W-1:0];
  endfunction

  // Random value biased toward the interior sets and the set breakpoints
  function automatic logic signed [IN_W-1:0] pick_value();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = int'($urandom_range(0, 255)) - 128;
    end else if (r < 7) begin
      v = int'($urandom_range(0, 190)) - 95;
    end else begin
      v = 30 * int'($urandom_range(0, 6)) - 90 + int'($urandom_range(0, 4)) - 2;
    end
    return v[IN_W-1:0];
  endfunction

  task automatic push_req(input int a, input int s, input bit drain);
    ctrl_req_t req;
    req.angle = a[IN_W-1:0];
    req.speed = s[IN_W-1:0];
    req.drain_first = drain;
    pending_reqs.push_back(req);
  endtask

  // Sender: bursts of requests separated by random gaps
  int  burst_left = 1;
  int  gap_left   = 0;
  bit  offer_next;
  ctrl_req_t next_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      angle_i    <= '0;
      speed_i    <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      offer_next = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        drive_expected.push_back('{angle_i, speed_i, predict_drive(angle_i, speed_i)});
        offer_next = 1'b0;
      end
      if (!offer_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && drive_expected.size() != 0)) begin
          next_req = pending_reqs.pop_front();
          angle_i <= next_req.angle;
          speed_i <= next_req.speed;
          offer_next = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid_i <= offer_next;
    end
  end

  // Long receiver hold-off, once, to fill the pipeline and stall the input
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic rx_hold = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left = 0;
      hold_done = 1'b0;
      rx_hold  <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      rx_hold <= (hold_left > 0);
    end
  end

  // Receiver: stall pattern picked at random from free, coin, sparse and mostly-ready
  int rx_cycle = 0;
  int rx_mode  = RX_FREE;
  bit ready_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_cycle = 0;
      rx_mode  = RX_FREE;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) begin
        rx_mode = $urandom_range(RX_FREE, RX_MOSTLY);
      end
      case (rx_mode)
        RX_FREE:   ready_next = 1'b1;
        RX_COIN:   ready_next = 1'($urandom_range(0, 1));
        RX_SPARSE: ready_next = (rx_cycle % 4 == 0);
        default:   ready_next = ($urandom_range(0, 6) != 0);
      endcase
      out_ready_i <= ready_next && !rx_hold;
    end
  end

  // Result check against the oldest outstanding request
  drive_exp_t got_exp;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_expected.size() == 0) begin
        if (mismatch_count < REPORT_MAX) begin
          $display("unexpected result: drive=%0d", drive_o);
        end
        mismatch_count++;
      end else begin
        got_exp = drive_expected.pop_front();
        if (drive_o !== got_exp.drive) begin
          if (mismatch_count < REPORT_MAX) begin
            $display("drive mismatch: angle=%0d speed=%0d expected=%0d actual=%0d",
                     got_exp.angle, got_exp.speed, got_exp.drive, drive_o);
          end
          mismatch_count++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int a;
    int s;

    // Directed: extremes, saturation, speed mirroring, breakpoints
    push_req(0, 0, 1'b0);
    push_req(-128, -128, 1'b0);  // speed -128 stays as is with negative angle
    push_req(127, 127, 1'b0);
    push_req(-128, 127, 1'b0);
    push_req(127, -128, 1'b0);
    push_req(-90, -90, 1'b0);
    push_req(90, 90, 1'b0);
    push_req(-1, 1, 1'b0);
    push_req(-1, 127, 1'b0);
    push_req(-45, 100, 1'b0);
    push_req(-30, -128, 1'b0);
    push_req(45, -45, 1'b0);
    push_req(15, 20, 1'b0);
    push_req(-15, -20, 1'b0);
    push_req(60, 30, 1'b0);
    push_req(-60, 0, 1'b0);
    push_req(30, -95, 1'b0);
    push_req(95, -30, 1'b0);
    push_req(-100, 50, 1'b0);
    push_req(1, -1, 1'b0);
    push_req(75, -75, 1'b0);
    push_req(-91, 91, 1'b0);
    push_req(0, 10, 1'b1);

    // Random requests, some with the mirroring case forced
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if ($urandom_range(0, 7) == 0) begin
        a = -int'($urandom_range(1, 128));
        s = $urandom_range(1, 127);
      end else begin
        a = pick_value();
        s = pick_value();
      end
      push_req(a, s, (n % DRAIN_EVERY) == DRAIN_EVERY - 1);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || drive_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && drive_expected.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fasc_pkg.sv
rtl/fasc_fuzz.sv
rtl/fasc_accum.sv
rtl/fasc_div_stage.sv
rtl/fuzzy_angle_speed_controller.sv
tb/testbench.sv
